[hw/rtl/spp_pkg.sv]
// Shared types, widths and corner tables for the sphere point projection pipeline.
// Used by spp_front, spp_sqrt, spp_div and sphere_point_projection_top.
`timescale 1ns / 1ps
`default_nettype none
package spp_pkg;

  localparam int WGT_W  = 7;   // input weight width
  localparam int IDX_W  = 4;   // corner index width
  localparam int CW     = 18;  // signed Q1.16 corner coordinate
  localparam int SW     = 26;  // signed weighted sum component
  localparam int MAG_W  = 25;  // magnitude of a sum component
  localparam int SQ_W   = 2 * MAG_W;
  localparam int N2_W   = 52;  // sum of three squares
  localparam int V_W    = N2_W + 6;
  localparam int RT_W   = V_W / 2;  // root width
  localparam int REM_W  = RT_W + 2; // sqrt remainder width
  localparam int D_W    = RT_W + 1; // divisor 2*M
  localparam int Q_W    = 16;       // quotient width, q never exceeds 32768
  localparam int NUM_W  = MAG_W + 20;
  localparam int OUT_W  = 16;

  localparam logic [1:0] KIND_TET = 2'd0;
  localparam logic [1:0] KIND_OCT = 2'd1;
  localparam logic [1:0] KIND_ICO = 2'd2;

  localparam logic signed [CW-1:0] QT   = 18'sd55748;
  localparam logic signed [CW-1:0] QZ   = 18'sd34454;
  localparam logic signed [CW-1:0] QA   = 18'sd21845;
  localparam logic signed [CW-1:0] QB   = 18'sd30894;
  localparam logic signed [CW-1:0] QB2  = 18'sd61788;
  localparam logic signed [CW-1:0] QC   = 18'sd53510;
  localparam logic signed [CW-1:0] QONE = 18'sd65536;
  localparam logic signed [CW-1:0] QNIL = 18'sd0;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  // Request side-band that travels with every stage from the front squares stage onward
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  bad;
    logic                  zero;
  } spp_pay_t;

  function automatic logic [IDX_W-1:0] corner_count(input logic [1:0] kind);
    logic [IDX_W-1:0] cnt;
    unique case (kind)
      KIND_TET: cnt = 4'd4;
      KIND_OCT: cnt = 4'd6;
      default:  cnt = 4'd12;
    endcase
    return cnt;
  endfunction

  function automatic vec_t corner_lookup(input logic [1:0] kind, input logic [IDX_W-1:0] idx);
    vec_t c;
    c = '{QNIL, QNIL, QNIL};
    unique case (kind)
      KIND_TET: begin
        case (idx)
          4'd0: c = '{QNIL, QB2, -QA};
          4'd1: c = '{-QC, -QB, -QA};
          4'd2: c = '{QC, -QB, -QA};
          4'd3: c = '{QNIL, QNIL, QONE};
          default: c = '{QNIL, QNIL, QNIL};
        endcase
      end
      KIND_OCT: begin
        case (idx)
          4'd0: c = '{QNIL, QNIL, QONE};
          4'd1: c = '{QNIL, QNIL, -QONE};
          4'd2: c = '{QONE, QNIL, QNIL};
          4'd3: c = '{-QONE, QNIL, QNIL};
          4'd4: c = '{QNIL, -QONE, QNIL};
          4'd5: c = '{QNIL, QONE, QNIL};
          default: c = '{QNIL, QNIL, QNIL};
        endcase
      end
      default: begin
        case (idx)
          4'd0:  c = '{QT, QZ, QNIL};
          4'd1:  c = '{-QT, -QZ, QNIL};
          4'd2:  c = '{-QT, QZ, QNIL};
          4'd3:  c = '{QT, -QZ, QNIL};
          4'd4:  c = '{QZ, QNIL, QT};
          4'd5:  c = '{-QZ, QNIL, -QT};
          4'd6:  c = '{QZ, QNIL, -QT};
          4'd7:  c = '{-QZ, QNIL, QT};
          4'd8:  c = '{QNIL, QT, QZ};
          4'd9:  c = '{QNIL, -QT, -QZ};
          4'd10: c = '{QNIL, -QT, QZ};
          4'd11: c = '{QNIL, QT, -QZ};
          default: c = '{QNIL, QNIL, QNIL};
        endcase
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/sphere_point_projection_top.sv]
// Sphere point projection: weighted corners of a base solid scaled onto the unit sphere.
// Instantiates spp_front, spp_sqrt and spp_div; depends on spp_pkg.
//
// Takes one request per cycle while not stalled and returns one result per request, in
// order, through 4 front stages (lookup, weighted sum, squares, norm), 29 square-root
// stages (one root bit each), 17 divider stages (setup plus one quotient bit each) and
// the output register. All stages advance together; a stall on the output holds the
// whole pipe and stalls the input.
`timescale 1ns / 1ps
`default_nettype none
module sphere_point_projection_top #(
  parameter int MAX_WEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_corner_first,
  input  wire logic [6:0]  in_weight_first,
  input  wire logic [3:0]  in_corner_second,
  input  wire logic [6:0]  in_weight_second,
  input  wire logic [3:0]  in_corner_third,
  input  wire logic [6:0]  in_weight_third,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] out_x_coord,
  output logic signed [15:0] out_y_coord,
  output logic signed [15:0] out_z_coord,
  output logic             out_bad_corner
);
  import spp_pkg::*;

  logic [1:0] solid_kind_r;
  logic       en;

  logic                  f_valid;
  logic [V_W-1:0]        f_v;
  spp_pay_t              f_pay;
  logic                  s_valid;
  logic [RT_W-1:0]       s_root;
  spp_pay_t              s_pay;
  logic                  d_valid;
  logic [2:0][Q_W-1:0]   d_q;
  spp_pay_t              d_pay;

  logic                      out_valid_r;
  logic [2:0][OUT_W-1:0]     coord_r;
  logic                      bad_r;
  logic [2:0][OUT_W-1:0]     coord_nxt;

  // hold everything while a finished result waits
  assign in_stall = out_valid_r && out_stall;
  assign en       = !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      solid_kind_r <= KIND_ICO;
    end else if (cfg_wr_en) begin
      solid_kind_r <= cfg_wr_data;
    end
  end

  spp_front #(
    .MAX_WEIGHT(MAX_WEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .kind     (solid_kind_r),
    .corner   ({in_corner_third, in_corner_second, in_corner_first}),
    .weight   ({in_weight_third, in_weight_second, in_weight_first}),
    .out_valid(f_valid),
    .out_v    (f_v),
    .out_pay  (f_pay)
  );

  spp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (f_valid),
    .in_v     (f_v),
    .in_pay   (f_pay),
    .out_valid(s_valid),
    .out_root (s_root),
    .out_pay  (s_pay)
  );

  spp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s_valid),
    .in_root  (s_root),
    .in_pay   (s_pay),
    .out_valid(d_valid),
    .out_q    (d_q),
    .out_pay  (d_pay)
  );

  // apply sign and saturate; drop to zero on a bad corner or a zero sum
  always_comb begin
    logic [Q_W-1:0] q;
    for (int d = 0; d < 3; d++) begin
      q = (d_q[d] > 16'd32768) ? 16'd32768 : d_q[d];
      if (d_pay.bad || d_pay.zero) begin
        coord_nxt[d] = '0;
      end else if (d_pay.neg[d]) begin
        coord_nxt[d] = OUT_W'(-q);
      end else if (q[Q_W-1]) begin
        coord_nxt[d] = 16'h7FFF;
      end else begin
        coord_nxt[d] = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord_r <= coord_nxt;
      bad_r   <= d_pay.bad;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x_coord    = coord_r[0];
  assign out_y_coord    = coord_r[1];
  assign out_z_coord    = coord_r[2];
  assign out_bad_corner = bad_r;

  a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_corner |->
      out_x_coord == 16'sd0 && out_y_coord == 16'sd0 && out_z_coord == 16'sd0)
    else $error("bad corner result carries nonzero coordinates");

  a_unit_scale : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bad_corner &&
    (out_x_coord != 16'sd0 || out_y_coord != 16'sd0 || out_z_coord != 16'sd0) |->
      (out_x_coord >= 16'sd16384 || out_x_coord <= -16'sd16384 ||
       out_y_coord >= 16'sd16384 || out_y_coord <= -16'sd16384 ||
       out_z_coord >= 16'sd16384 || out_z_coord <= -16'sd16384))
    else $error("projected point is not on the unit sphere");

  a_kind_write : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> solid_kind_r == $past(cfg_wr_data))
    else $error("solid kind register missed a write");

endmodule
`default_nettype wire

[hw/rtl/spp_front.sv]
// Front stages: corner lookup, weighted sum, squares and squared norm.
// Depends on spp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spp_front #(
  parameter int MAX_WEIGHT = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [1:0]                   kind,
  input  wire logic [2:0][spp_pkg::IDX_W-1:0] corner,
  input  wire logic [2:0][spp_pkg::WGT_W-1:0] weight,
  output logic                              out_valid,
  output logic [spp_pkg::V_W-1:0]           out_v,
  output spp_pkg::spp_pay_t                 out_pay
);
  import spp_pkg::*;

  // stage 1: clamped weights and looked-up corners
  logic              v1_r;
  logic [2:0][WGT_W-1:0] w1_r;
  vec_t [2:0]        c1_r;
  logic              bad1_r;
  logic [2:0][WGT_W-1:0] w1_nxt;
  vec_t [2:0]        c1_nxt;
  logic              bad1_nxt;

  always_comb begin
    bad1_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      w1_nxt[i] = ({4'b0, weight[i]} > 11'(MAX_WEIGHT)) ? WGT_W'(MAX_WEIGHT) : weight[i];
      c1_nxt[i] = '{QNIL, QNIL, QNIL};
      if (weight[i] != '0) begin
        if (corner[i] >= corner_count(kind)) begin
          bad1_nxt = 1'b1;
        end else begin
          c1_nxt[i] = corner_lookup(kind, corner[i]);
        end
      end
    end
  end

  // stage 2: weighted sums
  logic                  v2_r;
  logic signed [2:0][SW-1:0] s2_r;
  logic                  bad2_r;
  logic signed [2:0][SW-1:0] s2_nxt;

  always_comb begin
    logic signed [SW-1:0] ws;
    for (int d = 0; d < 3; d++) s2_nxt[d] = '0;
    for (int i = 0; i < 3; i++) begin
      ws = SW'($signed({1'b0, w1_r[i]}));
      s2_nxt[0] = s2_nxt[0] + ws * SW'(c1_r[i].x);
      s2_nxt[1] = s2_nxt[1] + ws * SW'(c1_r[i].y);
      s2_nxt[2] = s2_nxt[2] + ws * SW'(c1_r[i].z);
    end
  end

  // stage 3: magnitudes and squares
  logic                   v3_r;
  logic [2:0][SQ_W-1:0]   sq3_r;
  spp_pay_t               pay3_r;
  logic [2:0][SQ_W-1:0]   sq3_nxt;
  spp_pay_t               pay3_nxt;

  always_comb begin
    pay3_nxt.bad  = bad2_r;
    pay3_nxt.zero = 1'b0;
    for (int d = 0; d < 3; d++) begin
      pay3_nxt.neg[d] = s2_r[d][SW-1];
      pay3_nxt.mag[d] = s2_r[d][SW-1] ? MAG_W'(-s2_r[d]) : MAG_W'(s2_r[d]);
      sq3_nxt[d]      = SQ_W'(pay3_nxt.mag[d]) * SQ_W'(pay3_nxt.mag[d]);
    end
  end

  // stage 4: squared norm
  logic            v4_r;
  logic [N2_W-1:0] n2_r;
  spp_pay_t        pay4_r;
  logic [N2_W-1:0] n2_nxt;
  spp_pay_t        pay4_nxt;

  assign n2_nxt = N2_W'(sq3_r[0]) + N2_W'(sq3_r[1]) + N2_W'(sq3_r[2]);

  always_comb begin
    pay4_nxt      = pay3_r;
    pay4_nxt.zero = (n2_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r        <= w1_nxt;
      c1_r        <= c1_nxt;
      bad1_r      <= bad1_nxt;
      s2_r        <= s2_nxt;
      bad2_r      <= bad1_r;
      sq3_r       <= sq3_nxt;
      pay3_r      <= pay3_nxt;
      n2_r        <= n2_nxt;
      pay4_r      <= pay4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_v     = {n2_r, 6'b0};
  assign out_pay   = pay4_r;

endmodule
`default_nettype wire

[hw/rtl/spp_sqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on spp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spp_sqrt (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [spp_pkg::V_W-1:0] in_v,
  input  spp_pkg::spp_pay_t            in_pay,
  output logic                         out_valid,
  output logic [spp_pkg::RT_W-1:0]     out_root,
  output spp_pkg::spp_pay_t            out_pay
);
  import spp_pkg::*;

  logic                 val_r  [RT_W+1];
  logic [REM_W-1:0]     rem_r  [RT_W+1];
  logic [RT_W-1:0]      root_r [RT_W+1];
  logic [V_W-1:0]       v_r    [RT_W+1];
  spp_pay_t             pay_r  [RT_W+1];

  assign val_r[0]  = in_valid;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign v_r[0]    = in_v;
  assign pay_r[0]  = in_pay;

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    localparam int BI = RT_W - 1 - k;
    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    logic             ge;

    assign rem2  = {rem_r[k], v_r[k][2*BI+1 -: 2]};
    assign trial = {1'b0, (REM_W-1)'(root_r[k]), 2'b01};
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[k+1] <= 1'b0;
      end else if (en) begin
        val_r[k+1] <= val_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
        root_r[k+1] <= {root_r[k][RT_W-2:0], ge};
        v_r[k+1]    <= v_r[k];
        pay_r[k+1]  <= pay_r[k];
      end
    end
  end

  assign out_valid = val_r[RT_W];
  assign out_root  = root_r[RT_W];
  assign out_pay   = pay_r[RT_W];

endmodule
`default_nettype wire

[hw/rtl/spp_div.sv]
// Pipelined restoring divider for the three components, one quotient bit per stage.
// Forms q = (mag * 2^19 + M) / (2 * M). Depends on spp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spp_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [spp_pkg::RT_W-1:0]  in_root,
  input  spp_pkg::spp_pay_t              in_pay,
  output logic                           out_valid,
  output logic [2:0][spp_pkg::Q_W-1:0]   out_q,
  output spp_pkg::spp_pay_t              out_pay
);
  import spp_pkg::*;

  logic                  val_r [Q_W+2];
  logic [D_W-1:0]        d_r   [Q_W+2];
  logic [2:0][D_W-1:0]   rem_r [Q_W+2];
  logic [2:0][Q_W-1:0]   lo_r  [Q_W+2];
  logic [2:0][Q_W-1:0]   q_r   [Q_W+2];
  spp_pay_t              pay_r [Q_W+2];

  logic [2:0][NUM_W-1:0] num;

  // twice the numerator: mag * 2^20 + 2 * M
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      num[d] = {in_pay.mag[d], 20'b0} + NUM_W'({in_root, 1'b0});
    end
  end

  assign val_r[0] = in_valid;
  assign d_r[0]   = '0;
  assign rem_r[0] = '0;
  assign lo_r[0]  = '0;
  assign q_r[0]   = '0;
  assign pay_r[0] = in_pay;

  // setup stage: halve numerator against 2*M, top bits already below the divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r[1] <= 1'b0;
    end else if (en) begin
      val_r[1] <= val_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[1]   <= {in_root, 1'b0};
      pay_r[1] <= pay_r[0];
      q_r[1]   <= '0;
      for (int d = 0; d < 3; d++) begin
        rem_r[1][d] <= D_W'(num[d][NUM_W-1:Q_W+1]);
        lo_r[1][d]  <= num[d][Q_W:1];
      end
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [2:0][D_W:0] rem2;
    logic [2:0]        ge;

    always_comb begin
      for (int d = 0; d < 3; d++) begin
        rem2[d] = {rem_r[k][d], lo_r[k][d][Q_W-k]};
        ge[d]   = (rem2[d] >= {1'b0, d_r[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[k+1] <= 1'b0;
      end else if (en) begin
        val_r[k+1] <= val_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[k+1]   <= d_r[k];
        lo_r[k+1]  <= lo_r[k];
        pay_r[k+1] <= pay_r[k];
        for (int d = 0; d < 3; d++) begin
          rem_r[k+1][d] <= ge[d] ? D_W'(rem2[d] - {1'b0, d_r[k]}) : D_W'(rem2[d]);
          q_r[k+1][d]   <= {q_r[k][d][Q_W-2:0], ge[d]};
        end
      end
    end
  end

  assign out_valid = val_r[Q_W+1];
  assign out_q     = q_r[Q_W+1];
  assign out_pay   = pay_r[Q_W+1];

endmodule
`default_nettype wire

[dv/tb_sphere_point_projection_top.sv]
// Self-checking testbench for sphere_point_projection_top.
// Predicts each projected point from the corner tables and compares results in order.
// Depends on spp_pkg and the sphere_point_projection_top RTL.
`timescale 1ns / 1ps
module tb_sphere_point_projection_top;
  import spp_pkg::*;

  localparam int MAXW = 64;
  localparam int PIPE_LAT = 52;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [3:0] c[3];
    logic [6:0] w[3];
  } point_req_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic bad;
  } sphere_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = 2'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_corner_first = '0, in_corner_second = '0, in_corner_third = '0;
  logic [6:0] in_weight_first = '0, in_weight_second = '0, in_weight_third = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_x_coord, out_y_coord, out_z_coord;
  logic out_bad_corner;

  sphere_point_projection_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_corner_first(in_corner_first), .in_weight_first(in_weight_first),
    .in_corner_second(in_corner_second), .in_weight_second(in_weight_second),
    .in_corner_third(in_corner_third), .in_weight_third(in_weight_third),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x_coord(out_x_coord), .out_y_coord(out_y_coord),
    .out_z_coord(out_z_coord), .out_bad_corner(out_bad_corner)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  point_req_t pending_reqs[$];
  sphere_pt_t expected_pts[$];
  logic [1:0] solid_sel = KIND_ICO;
  bit quiet_mode = 1'b0;
  bit hold_sender = 1'b0;
  bit in_held = 1'b0;
  int mismatches = 0;
  int checked = 0;
  int bad_seen = 0;
  int cycles = 0;
  int sent = 0;

  // Fixed corner constants for each solid, independent of the package lookup
  function automatic void solid_corner(input logic [1:0] kind, input int idx,
                                       output longint v[3]);
    longint t[3];
    t = '{0, 0, 0};
    case (kind)
      KIND_TET: case (idx)
        0: t = '{0, 61788, -21845};
        1: t = '{-53510, -30894, -21845};
        2: t = '{53510, -30894, -21845};
        3: t = '{0, 0, 65536};
        default: ;
      endcase
      KIND_OCT: case (idx)
        0: t = '{0, 0, 65536};
        1: t = '{0, 0, -65536};
        2: t = '{65536, 0, 0};
        3: t = '{-65536, 0, 0};
        4: t = '{0, -65536, 0};
        5: t = '{0, 65536, 0};
        default: ;
      endcase
      default: case (idx)
        0: t = '{55748, 34454, 0};
        1: t = '{-55748, -34454, 0};
        2: t = '{-55748, 34454, 0};
        3: t = '{55748, -34454, 0};
        4: t = '{34454, 0, 55748};
        5: t = '{-34454, 0, -55748};
        6: t = '{34454, 0, -55748};
        7: t = '{-34454, 0, 55748};
        8: t = '{0, 55748, 34454};
        9: t = '{0, -55748, -34454};
        10: t = '{0, -55748, 34454};
        11: t = '{0, 55748, -34454};
        default: ;
      endcase
    endcase
    v = t;
  endfunction

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic sphere_pt_t project_point(input point_req_t p, input logic [1:0] sel);
    sphere_pt_t res;
    logic [1:0] kind;
    int ncorners;
    longint acc[3], cv[3], w;
    logic [63:0] n2, m, mag, q;
    longint sv;
    acc = '{0, 0, 0};
    res = '{0, 0, 0, 1'b0};
    kind = (sel == 2'd3) ? KIND_ICO : sel;
    ncorners = (kind == KIND_TET) ? 4 : (kind == KIND_OCT) ? 6 : 12;
    for (int i = 0; i < 3; i++) begin
      w = (p.w[i] > MAXW) ? MAXW : p.w[i];
      if (w != 0) begin
        if (p.c[i] >= ncorners) begin
          res.bad = 1'b1;
        end else begin
          solid_corner(kind, p.c[i], cv);
          for (int d = 0; d < 3; d++) acc[d] += w * cv[d];
        end
      end
    end
    if (res.bad) return res;
    n2 = 0;
    for (int d = 0; d < 3; d++) n2 += acc[d] * acc[d];
    if (n2 == 0) return res;
    m = int_root(n2 << 6);
    for (int d = 0; d < 3; d++) begin
      mag = (acc[d] < 0) ? -acc[d] : acc[d];
      q = ((mag << 19) + m) / (2 * m);
      if (q > 32768) q = 32768;
      sv = (acc[d] < 0) ? -longint'(q) : longint'(q);
      if (sv > 32767) sv = 32767;
      case (d)
        0: res.x = sv[15:0];
        1: res.y = sv[15:0];
        default: res.z = sv[15:0];
      endcase
    end
    return res;
  endfunction

  function automatic point_req_t mk_req(input int c0, w0, c1, w1, c2, w2);
    point_req_t p;
    p.c[0] = 4'(c0); p.w[0] = 7'(w0);
    p.c[1] = 4'(c1); p.w[1] = 7'(w1);
    p.c[2] = 4'(c2); p.w[2] = 7'(w2);
    return p;
  endfunction

  // Mostly valid corners with random weights; some noise with any index or weight
  function automatic point_req_t rand_req(input logic [1:0] sel);
    point_req_t p;
    int ncorners;
    ncorners = (sel == KIND_TET) ? 4 : (sel == KIND_OCT) ? 6 : 12;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        p.c[i] = 4'($urandom_range(0, 15));
        p.w[i] = 7'($urandom_range(0, 127));
      end else begin
        p.c[i] = 4'($urandom_range(0, ncorners - 1));
        case ($urandom_range(0, 5))
          0: p.w[i] = 7'd0;
          1: p.w[i] = 7'($urandom_range(60, 127));
          default: p.w[i] = 7'($urandom_range(1, 64));
        endcase
      end
    end
    return p;
  endfunction

  // Driver: hold payload while stalled, advance on acceptance
  always @(negedge clk) begin
    bit idle;
    point_req_t p;
    if (rst_n && !in_held) begin
      idle = !quiet_mode && ($urandom_range(0, 99) < 7);
      if (pending_reqs.size() != 0 && !idle && !hold_sender) begin
        p = pending_reqs.pop_front();
        expected_pts.push_back(project_point(p, solid_sel));
        in_corner_first <= p.c[0]; in_weight_first <= p.w[0];
        in_corner_second <= p.c[1]; in_weight_second <= p.w[1];
        in_corner_third <= p.c[2]; in_weight_third <= p.w[2];
        in_valid <= 1'b1;
        sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && !quiet_mode && ($urandom_range(0, 99) < 7);
  end

  // Monitor
  always @(posedge clk) begin
    sphere_pt_t e;
    cycles++;
    // remember whether the request on the input was refused at this edge
    in_held <= in_valid && in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d y=%0d z=%0d bad=%0b",
                                       out_x_coord, out_y_coord, out_z_coord, out_bad_corner);
      end else begin
        e = expected_pts.pop_front();
        checked++;
        if (out_bad_corner) bad_seen++;
        if (out_x_coord !== e.x || out_y_coord !== e.y || out_z_coord !== e.z ||
            out_bad_corner !== e.bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp x=%0d y=%0d z=%0d bad=%0b got x=%0d y=%0d z=%0d bad=%0b",
                     checked, e.x, e.y, e.z, e.bad,
                     out_x_coord, out_y_coord, out_z_coord, out_bad_corner);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expected_pts.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drain_pipe();
    while (pending_reqs.size() != 0 || in_valid || expected_pts.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic write_solid(input logic [1:0] kind);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= kind;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    solid_sel = kind;
  endtask

  initial begin
    logic [1:0] phase_kind[5];
    phase_kind = '{KIND_TET, KIND_OCT, 2'd3, KIND_ICO, KIND_TET};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, icosahedron from reset
    pending_reqs.push_back(mk_req(0, 64, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(15, 127, 15, 127, 15, 127));
    pending_reqs.push_back(mk_req(0, 0, 15, 0, 7, 0));
    pending_reqs.push_back(mk_req(0, 5, 1, 5, 4, 0));
    pending_reqs.push_back(mk_req(0, 127, 4, 100, 8, 65));
    pending_reqs.push_back(mk_req(11, 1, 11, 1, 11, 64));
    pending_reqs.push_back(mk_req(12, 1, 0, 10, 1, 10));
    pending_reqs.push_back(mk_req(3, 64, 12, 0, 5, 1));
    pending_reqs.push_back(mk_req(10, 42, 9, 85, 6, 21));
    drain_pipe();
    write_solid(KIND_OCT);
    pending_reqs.push_back(mk_req(0, 64, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(1, 1, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(2, 1, 3, 0, 0, 0));
    pending_reqs.push_back(mk_req(3, 1, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(0, 1, 1, 1, 2, 0));
    pending_reqs.push_back(mk_req(6, 1, 0, 1, 0, 0));
    pending_reqs.push_back(mk_req(2, 64, 4, 64, 1, 64));
    drain_pipe();
    write_solid(KIND_TET);
    pending_reqs.push_back(mk_req(3, 64, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(0, 1, 1, 1, 2, 1));
    pending_reqs.push_back(mk_req(4, 9, 0, 1, 0, 0));
    pending_reqs.push_back(mk_req(0, 127, 1, 33, 2, 7));
    drain_pipe();

    foreach (phase_kind[k]) begin
      write_solid(phase_kind[k]);
      quiet_mode = (k == 1);
      for (int n = 0; n < 240; n++) pending_reqs.push_back(rand_req(solid_sel));
      if (k == 2) begin
        // Pause the sender until the pipe is empty
        while (pending_reqs.size() > 120) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_pts.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain_pipe();
      quiet_mode = 1'b0;
    end

    $display("covered %0d requests over all solid selections, %0d bad-corner results",
             sent, bad_seen);
    if (mismatches == 0 && expected_pts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches in %0d results", mismatches, checked);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
